/* design/ewl_pkg.sv */
package ewl_pkg;

  localparam int MAX_INDEXES  = 16;
  localparam int IDX_W        = 4;
  localparam int SLOT_W       = 12;
  localparam int ADDR_W       = 10;
  localparam int SEQ_W        = 32;
  localparam int DATA_W       = 16;
  localparam int CNT_W        = 5;
  localparam int ENT_W        = 8;

  localparam logic [SEQ_W-1:0] ERASED_SEQ      = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] RESET_INDEX_CNT = 5'd1;
  localparam logic [ENT_W-1:0] RESET_ENTRIES   = 8'd170;

  localparam logic [2:0] CMD_READ       = 3'd0;
  localparam logic [2:0] CMD_UPDATE     = 3'd1;
  localparam logic [2:0] CMD_WRITE      = 3'd2;
  localparam logic [2:0] CMD_SCAN_START = 3'd3;
  localparam logic [2:0] CMD_SCAN_REC   = 3'd4;

  localparam logic REG_INDEX_COUNT = 1'b0;
  localparam logic REG_ENTRIES     = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] index_count;
    logic [ENT_W-1:0] entries;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

/* design/ewl_cfg.sv */
module ewl_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ewl_pkg::cfg_t      cfg
);

  logic [ewl_pkg::CNT_W-1:0] index_count;
  logic [ewl_pkg::ENT_W-1:0] entries;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_count <= ewl_pkg::RESET_INDEX_CNT;
      entries     <= ewl_pkg::RESET_ENTRIES;
    end else if (wr_en) begin
      case (paddr[2])
        ewl_pkg::REG_INDEX_COUNT: index_count <= pwdata[ewl_pkg::CNT_W-1:0];
        ewl_pkg::REG_ENTRIES:     entries     <= pwdata[ewl_pkg::ENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ewl_pkg::REG_INDEX_COUNT: prdata = {27'd0, index_count};
      ewl_pkg::REG_ENTRIES:     prdata = {24'd0, entries};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.index_count = index_count;
  assign cfg.entries     = entries;

endmodule

/* design/ewl_ctrl.sv */
module ewl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ewl_pkg::dp_status_t status,
  output ewl_pkg::ctrl_cmd_t  ctl
);

  ewl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ewl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    case (state)
      ewl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ewl_pkg::ST_EXEC;
        end
      end
      ewl_pkg::ST_EXEC: begin
        // hold until the output register can take the result
        if (!status.out_busy) begin
          ctl.exec   = 1'b1;
          state_next = ewl_pkg::ST_IDLE;
        end
      end
      default: state_next = ewl_pkg::ST_IDLE;
    endcase
  end

endmodule

/* design/ewl_dp.sv */
module ewl_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  ewl_pkg::cfg_t              cfg,
  input  ewl_pkg::ctrl_cmd_t         ctl,
  output ewl_pkg::dp_status_t        status,
  input  logic [2:0]                 cmd,
  input  logic [ewl_pkg::IDX_W-1:0]  index,
  input  logic [ewl_pkg::DATA_W-1:0] value,
  input  logic [ewl_pkg::ENT_W-1:0]  slot,
  input  logic [ewl_pkg::SEQ_W-1:0]  stored_seq,
  input  logic [ewl_pkg::DATA_W-1:0] stored_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ewl_pkg::DATA_W-1:0] value_out,
  output logic                       write_valid,
  output logic [ewl_pkg::ADDR_W-1:0] write_address,
  output logic [ewl_pkg::SEQ_W-1:0]  write_seq,
  output logic [ewl_pkg::DATA_W-1:0] write_data,
  output logic                       bad_index
);

  // per-index tables
  logic [ewl_pkg::SLOT_W-1:0] cur_slot [ewl_pkg::MAX_INDEXES];
  logic [ewl_pkg::SEQ_W-1:0]  last_seq [ewl_pkg::MAX_INDEXES];
  logic [ewl_pkg::DATA_W-1:0] cached   [ewl_pkg::MAX_INDEXES];

  // captured request
  logic [2:0]                 cmd_q;
  logic [ewl_pkg::IDX_W-1:0]  idx_q;
  logic [ewl_pkg::DATA_W-1:0] value_q;
  logic [ewl_pkg::ENT_W-1:0]  slot_q;
  logic [ewl_pkg::SEQ_W-1:0]  sseq_q;
  logic [ewl_pkg::DATA_W-1:0] sdata_q;
  logic                       bad_q;
  logic [ewl_pkg::SLOT_W-1:0] base_q;
  logic [ewl_pkg::SLOT_W:0]   end_q;

  logic [ewl_pkg::SLOT_W-1:0] base_next;
  logic [ewl_pkg::SLOT_W:0]   end_next;

  logic [ewl_pkg::SLOT_W-1:0] cur;
  logic [ewl_pkg::SEQ_W-1:0]  seq;
  logic [ewl_pkg::DATA_W-1:0] cval;
  logic [ewl_pkg::SLOT_W:0]   inc;
  logic [ewl_pkg::SLOT_W-1:0] next_slot;
  logic [ewl_pkg::SEQ_W-1:0]  seq_inc;
  logic [ewl_pkg::SLOT_W+1:0] addr_full;
  logic                       wr;
  logic                       start;
  logic                       scan_ok;
  logic                       in_ring;
  logic [ewl_pkg::DATA_W-1:0] val_after;

  assign base_next = {8'd0, index} * {4'd0, cfg.entries};
  assign end_next  = {1'b0, base_next} + {5'd0, cfg.entries};

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= cmd;
      idx_q   <= index;
      value_q <= value;
      slot_q  <= slot;
      sseq_q  <= stored_seq;
      sdata_q <= stored_data;
      bad_q   <= {1'b0, index} >= cfg.index_count;
      base_q  <= base_next;
      end_q   <= end_next;
    end
  end

  assign cur     = cur_slot[idx_q];
  assign seq     = last_seq[idx_q];
  assign cval    = cached[idx_q];
  assign seq_inc = seq + 32'd1;
  assign inc     = {1'b0, cur} + 13'd1;
  // wrap to the ring base
  assign next_slot = (inc >= end_q) ? base_q : inc[ewl_pkg::SLOT_W-1:0];
  assign addr_full = {next_slot, 2'b00} + {1'b0, next_slot, 1'b0};
  assign in_ring   = ({5'd0, slot_q} >= {1'b0, base_q}) && ({5'd0, slot_q} < end_q);

  always_comb begin
    wr      = 1'b0;
    start   = 1'b0;
    scan_ok = 1'b0;
    case (cmd_q)
      ewl_pkg::CMD_UPDATE:     wr = (cval != value_q);
      ewl_pkg::CMD_WRITE:      wr = 1'b1;
      ewl_pkg::CMD_SCAN_START: start = 1'b1;
      ewl_pkg::CMD_SCAN_REC:
        scan_ok = in_ring && (sseq_q > seq) && (sseq_q != ewl_pkg::ERASED_SEQ);
      default: ;
    endcase
    if (bad_q) begin
      wr      = 1'b0;
      start   = 1'b0;
      scan_ok = 1'b0;
    end
  end

  always_comb begin
    if (bad_q) begin
      val_after = '0;
    end else if (wr) begin
      val_after = value_q;
    end else if (start) begin
      val_after = '0;
    end else if (scan_ok) begin
      val_after = sdata_q;
    end else begin
      val_after = cval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ewl_pkg::MAX_INDEXES; i++) begin
        cur_slot[i] <= '0;
        last_seq[i] <= '0;
        cached[i]   <= '0;
      end
    end else if (ctl.exec) begin
      if (wr) begin
        cur_slot[idx_q] <= next_slot;
        last_seq[idx_q] <= seq_inc;
        cached[idx_q]   <= value_q;
      end else if (start) begin
        cur_slot[idx_q] <= base_q;
        last_seq[idx_q] <= '0;
        cached[idx_q]   <= '0;
      end else if (scan_ok) begin
        cur_slot[idx_q] <= {4'd0, slot_q};
        last_seq[idx_q] <= sseq_q;
        cached[idx_q]   <= sdata_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      value_out     <= val_after;
      write_valid   <= wr;
      write_address <= wr ? addr_full[ewl_pkg::ADDR_W-1:0] : '0;
      write_seq     <= wr ? seq_inc : '0;
      write_data    <= wr ? value_q : '0;
      bad_index     <= bad_q;
    end
  end

  assign status.out_busy = out_valid & ~out_ready;

endmodule

/* design/eeprom_wear_level_ring.sv */
// Each request is captured when accepted; the per-index table read-modify-write then
// puts its result in the output register. The two steps run back to back, a stalled
// output holds the second step, and no new request is taken until it is done.
// A finished result may wait in the output register while the next request is taken.
// Reset (synchronous, active high) zeroes the slot, sequence and value tables,
// sets index_count to 1 and entries_per_index to 170, and empties the output.
module eeprom_wear_level_ring (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 cmd,
  input  logic [ewl_pkg::IDX_W-1:0]  index,
  input  logic [ewl_pkg::DATA_W-1:0] value,
  input  logic [ewl_pkg::ENT_W-1:0]  slot,
  input  logic [ewl_pkg::SEQ_W-1:0]  stored_seq,
  input  logic [ewl_pkg::DATA_W-1:0] stored_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ewl_pkg::DATA_W-1:0] value_out,
  output logic                       write_valid,
  output logic [ewl_pkg::ADDR_W-1:0] write_address,
  output logic [ewl_pkg::SEQ_W-1:0]  write_seq,
  output logic [ewl_pkg::DATA_W-1:0] write_data,
  output logic                       bad_index
);

  ewl_pkg::cfg_t       cfg;
  ewl_pkg::ctrl_cmd_t  ctl;
  ewl_pkg::dp_status_t status;

  ewl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ewl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctl      (ctl)
  );

  ewl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctl           (ctl),
    .status        (status),
    .cmd           (cmd),
    .index         (index),
    .value         (value),
    .slot          (slot),
    .stored_seq    (stored_seq),
    .stored_data   (stored_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value_out     (value_out),
    .write_valid   (write_valid),
    .write_address (write_address),
    .write_seq     (write_seq),
    .write_data    (write_data),
    .bad_index     (bad_index)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_bad_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_index |-> !write_valid && value_out == '0 && write_seq == '0)
    else $error("bad index result carries data");

  a_idle_write_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> write_address == '0 && write_data == '0)
    else $error("write fields set without a write");
`endif

endmodule

/* tb/tb_eeprom_wear_level_ring.sv */
`timescale 1ns / 100ps

module tb_eeprom_wear_level_ring;

  localparam int RECORD_BYTES = 6;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;

  // commands the block does not decode; they behave as a read
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]                 cmd;
    logic [ewl_pkg::IDX_W-1:0]  index;
    logic [ewl_pkg::DATA_W-1:0] value;
    logic [ewl_pkg::ENT_W-1:0]  slot;
    logic [ewl_pkg::SEQ_W-1:0]  stored_seq;
    logic [ewl_pkg::DATA_W-1:0] stored_data;
  } ring_req_t;

  typedef struct packed {
    logic [ewl_pkg::DATA_W-1:0] value_out;
    logic                       write_valid;
    logic [ewl_pkg::ADDR_W-1:0] write_address;
    logic [ewl_pkg::SEQ_W-1:0]  write_seq;
    logic [ewl_pkg::DATA_W-1:0] write_data;
    logic                       bad_index;
  } ring_result_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [2:0] cmd;
  logic [ewl_pkg::IDX_W-1:0] index;
  logic [ewl_pkg::DATA_W-1:0] value;
  logic [ewl_pkg::ENT_W-1:0] slot;
  logic [ewl_pkg::SEQ_W-1:0] stored_seq;
  logic [ewl_pkg::DATA_W-1:0] stored_data;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ewl_pkg::DATA_W-1:0] value_out;
  logic write_valid;
  logic [ewl_pkg::ADDR_W-1:0] write_address;
  logic [ewl_pkg::SEQ_W-1:0] write_seq;
  logic [ewl_pkg::DATA_W-1:0] write_data;
  logic bad_index;

  // mirror of the block's tables and registers
  logic [ewl_pkg::CNT_W-1:0]  cfg_count   = ewl_pkg::RESET_INDEX_CNT;
  logic [ewl_pkg::ENT_W-1:0]  cfg_entries = ewl_pkg::RESET_ENTRIES;
  int unsigned                ring_pos  [ewl_pkg::MAX_INDEXES] = '{default: 0};
  logic [ewl_pkg::SEQ_W-1:0]  seq_held  [ewl_pkg::MAX_INDEXES] = '{default: '0};
  logic [ewl_pkg::DATA_W-1:0] value_held[ewl_pkg::MAX_INDEXES] = '{default: '0};

  ring_result_t pending_records[$];
  ring_result_t oldest;
  int fail_count  = 0;
  int cycle_count = 0;
  int idle_in_pct;
  int idle_out_pct;
  int hold_starts = 0;
  int hold_seen;
  int hold_left;

  eeprom_wear_level_ring u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .index        (index),
    .value        (value),
    .slot         (slot),
    .stored_seq   (stored_seq),
    .stored_data  (stored_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_out    (value_out),
    .write_valid  (write_valid),
    .write_address(write_address),
    .write_seq    (write_seq),
    .write_data   (write_data),
    .bad_index    (bad_index)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one request to the mirrored tables and return the record it produces.
  function automatic ring_result_t advance_ring(input ring_req_t r);
    ring_result_t res;
    int unsigned  base;
    int unsigned  ring_end;
    int unsigned  nxt;
    logic [31:0]  addr_full;
    logic         wr;
    res = '0;
    wr  = 1'b0;
    if (r.index >= cfg_count) begin
      res.bad_index = 1'b1;
      return res;
    end
    base     = r.index * cfg_entries;
    ring_end = base + cfg_entries;
    case (r.cmd)
      ewl_pkg::CMD_UPDATE: begin
        wr = (value_held[r.index] != r.value);
      end
      ewl_pkg::CMD_WRITE: begin
        wr = 1'b1;
      end
      ewl_pkg::CMD_SCAN_START: begin
        ring_pos[r.index]   = base;
        seq_held[r.index]   = '0;
        value_held[r.index] = '0;
      end
      ewl_pkg::CMD_SCAN_REC: begin
        if (r.slot >= base && r.slot < ring_end &&
            r.stored_seq > seq_held[r.index] && r.stored_seq != ewl_pkg::ERASED_SEQ) begin
          ring_pos[r.index]   = 32'(r.slot);
          seq_held[r.index]   = r.stored_seq;
          value_held[r.index] = r.stored_data;
        end
      end
      default: ;
    endcase
    if (wr) begin
      nxt = ring_pos[r.index] + 1;
      if (nxt >= ring_end) nxt = base;
      ring_pos[r.index]   = nxt;
      seq_held[r.index]   = seq_held[r.index] + 1'b1;
      value_held[r.index] = r.value;
      addr_full           = nxt * RECORD_BYTES;
      res.write_valid     = 1'b1;
      res.write_address   = addr_full[ewl_pkg::ADDR_W-1:0];
      res.write_seq       = seq_held[r.index];
      res.write_data      = r.value;
    end
    res.value_out = value_held[r.index];
    return res;
  endfunction

  function automatic ring_req_t request_of(input logic [2:0] c,
                                           input logic [ewl_pkg::IDX_W-1:0] i,
                                           input logic [ewl_pkg::DATA_W-1:0] v,
                                           input logic [ewl_pkg::ENT_W-1:0] s,
                                           input logic [ewl_pkg::SEQ_W-1:0] q,
                                           input logic [ewl_pkg::DATA_W-1:0] d);
    ring_req_t r;
    r.cmd         = c;
    r.index       = i;
    r.value       = v;
    r.slot        = s;
    r.stored_seq  = q;
    r.stored_data = d;
    return r;
  endfunction

  // Mostly well-formed traffic on in-range indexes; scan records aim at the
  // ring of their index with sequence numbers near the one held.
  function automatic ring_req_t random_request(input logic scan_only,
                                               input logic [ewl_pkg::IDX_W-1:0] scan_idx);
    ring_req_t   r;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] rnd;
    rnd           = $urandom;
    r.value       = rnd[ewl_pkg::DATA_W-1:0];
    rnd           = $urandom;
    r.slot        = rnd[ewl_pkg::ENT_W-1:0];
    r.stored_seq  = $urandom;
    rnd           = $urandom;
    r.stored_data = rnd[ewl_pkg::DATA_W-1:0];
    if (scan_only) begin
      r.index = scan_idx;
    end else if ($urandom_range(9) != 0 && cfg_count != 0) begin
      rnd     = $urandom_range(cfg_count - 1);
      r.index = rnd[ewl_pkg::IDX_W-1:0];
    end else begin
      rnd     = $urandom_range(ewl_pkg::MAX_INDEXES - 1);
      r.index = rnd[ewl_pkg::IDX_W-1:0];
    end
    pick = scan_only ? 80 : $urandom_range(99);
    if (pick < 15) begin
      r.cmd = ewl_pkg::CMD_READ;
    end else if (pick < 35) begin
      r.cmd = ewl_pkg::CMD_UPDATE;
    end else if (pick < 65) begin
      r.cmd = ewl_pkg::CMD_WRITE;
    end else if (pick < 70) begin
      r.cmd = ewl_pkg::CMD_SCAN_START;
    end else if (pick < 95) begin
      r.cmd = ewl_pkg::CMD_SCAN_REC;
    end else begin
      rnd   = $urandom_range(CMD_SPARE_HI, CMD_SPARE_LO);
      r.cmd = rnd[2:0];
    end
    if (r.cmd == ewl_pkg::CMD_UPDATE && $urandom_range(1) == 0)
      r.value = value_held[r.index];
    if (r.cmd == ewl_pkg::CMD_SCAN_REC) begin
      lo = r.index * cfg_entries;
      if (cfg_entries != 0 && lo <= 255 && $urandom_range(6) != 0) begin
        hi = lo + cfg_entries - 1;
        if (hi > 255) hi = 255;
        rnd    = $urandom_range(hi, lo);
        r.slot = rnd[ewl_pkg::ENT_W-1:0];
      end
      case ($urandom_range(9))
        0: r.stored_seq = ewl_pkg::ERASED_SEQ;
        1: r.stored_seq = ewl_pkg::ERASED_SEQ - 1;
        2: r.stored_seq = '0;
        3: ;
        4: r.stored_seq = seq_held[r.index] - $urandom_range(3);
        default: r.stored_seq = seq_held[r.index] + $urandom_range(20, 1);
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic send_request(input ring_req_t r);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= r.cmd;
    index       <= r.index;
    value       <= r.value;
    slot        <= r.slot;
    stored_seq  <= r.stored_seq;
    stored_data <= r.stored_data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_records.push_back(advance_ring(r));
  endtask

  task automatic stop_requests();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == ewl_pkg::REG_INDEX_COUNT)
      cfg_count = data[ewl_pkg::CNT_W-1:0];
    else
      cfg_entries = data[ewl_pkg::ENT_W-1:0];
    @(posedge clk);
  endtask

  task automatic setup_rings(input logic [ewl_pkg::CNT_W-1:0] n_idx,
                             input logic [ewl_pkg::ENT_W-1:0] n_ent);
    wait_drained();
    write_register(ewl_pkg::REG_INDEX_COUNT, 32'(n_idx));
    write_register(ewl_pkg::REG_ENTRIES, 32'(n_ent));
  endtask

  // Reset settings first, then all sixteen rings for the address overflow.
  task automatic test_directed();
    send_request(request_of(ewl_pkg::CMD_READ, 4'd0, 16'h0000, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(CMD_SPARE_HI, 4'd15, 16'hFFFF, 8'hFF, ewl_pkg::ERASED_SEQ,
                            16'hFFFF));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd0, 16'hFFFF, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_UPDATE, 4'd0, 16'hFFFF, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_UPDATE, 4'd0, 16'h0000, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(CMD_SPARE_LO, 4'd0, 16'h5A5A, 8'd3, 32'd9, 16'h1111));
    send_request(request_of(ewl_pkg::CMD_SCAN_START, 4'd0, 16'h0000, 8'd0, 32'd0, 16'h0000));
    // erased, adopted, older, then outside the ring
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd0, 16'h0000, 8'd5,
                            ewl_pkg::ERASED_SEQ, 16'h7777));
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd0, 16'h0000, 8'd169, 32'd7, 16'hABCD));
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd0, 16'h0000, 8'd20, 32'd6, 16'h2222));
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd0, 16'h0000, 8'd170, 32'd100, 16'h3333));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd0, 16'h8001, 8'd0, 32'd0, 16'h0000));
    // sequence number runs through all ones and wraps to zero
    send_request(request_of(ewl_pkg::CMD_SCAN_START, 4'd0, 16'h0000, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd0, 16'h0000, 8'd10,
                            ewl_pkg::ERASED_SEQ - 1, 16'h1234));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd0, 16'h4321, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd0, 16'h0001, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd0, 16'h0000, 8'd12, 32'd0, 16'h9999));
    send_request(request_of(CMD_SPARE_HI, 4'd0, 16'h0000, 8'd0, 32'd0, 16'h0000));
    stop_requests();
    setup_rings(5'd16, 8'd170);
    send_request(request_of(ewl_pkg::CMD_READ, 4'd15, 16'h0000, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_SCAN_START, 4'd15, 16'h0000, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd15, 16'hC3C3, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_UPDATE, 4'd15, 16'h3C3C, 8'd0, 32'd0, 16'h0000));
    stop_requests();
  endtask

  task automatic test_empty_ring();
    setup_rings(5'd16, 8'd0);
    send_request(request_of(ewl_pkg::CMD_SCAN_START, 4'd4, 16'h0000, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd4, 16'h00AA, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_WRITE, 4'd4, 16'h0055, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_SCAN_REC, 4'd4, 16'h0000, 8'd0, 32'd50, 16'hBEEF));
    send_request(request_of(ewl_pkg::CMD_UPDATE, 4'd4, 16'h0055, 8'd0, 32'd0, 16'h0000));
    send_request(request_of(ewl_pkg::CMD_READ, 4'd4, 16'h0000, 8'd0, 32'd0, 16'h0000));
    stop_requests();
  endtask

  task automatic test_random_traffic(input logic [ewl_pkg::CNT_W-1:0] n_idx,
                                     input logic [ewl_pkg::ENT_W-1:0] n_ent,
                                     input int n_items);
    int        sent;
    int        burst;
    ring_req_t r;
    setup_rings(n_idx, n_ent);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) begin
        // recovery: restart one ring, then feed it its stored records
        r     = random_request(1'b0, '0);
        r.cmd = ewl_pkg::CMD_SCAN_START;
        send_request(r);
        burst = $urandom_range(8, 2);
        repeat (burst) send_request(random_request(1'b1, r.index));
        sent += burst + 1;
      end else begin
        send_request(random_request(1'b0, '0));
        sent++;
      end
    end
    stop_requests();
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    wait_drained();
    hold_starts++;
    repeat (40) send_request(random_request(1'b0, '0));
    stop_requests();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_starts) begin
      hold_seen <= hold_starts;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected result", 32'(value_out), 32'd0);
      end else begin
        oldest = pending_records.pop_front();
        if (value_out !== oldest.value_out)
          report_mismatch("value_out", 32'(value_out), 32'(oldest.value_out));
        if (write_valid !== oldest.write_valid)
          report_mismatch("write_valid", 32'(write_valid), 32'(oldest.write_valid));
        if (write_address !== oldest.write_address)
          report_mismatch("write_address", 32'(write_address), 32'(oldest.write_address));
        if (write_seq !== oldest.write_seq)
          report_mismatch("write_seq", write_seq, oldest.write_seq);
        if (write_data !== oldest.write_data)
          report_mismatch("write_data", 32'(write_data), 32'(oldest.write_data));
        if (bad_index !== oldest.bad_index)
          report_mismatch("bad_index", 32'(bad_index), 32'(oldest.bad_index));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    cmd         <= ewl_pkg::CMD_READ;
    index       <= '0;
    value       <= '0;
    slot        <= '0;
    stored_seq  <= '0;
    stored_data <= '0;
    idle_in_pct  = 29;
    idle_out_pct = 70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_empty_ring();
    test_random_traffic(5'd16, 8'd170, 350);
    test_random_traffic(5'd1, 8'd1, 300);
    idle_in_pct  = 70;
    idle_out_pct = 29;
    test_random_traffic(5'd16, 8'd1, 300);
    test_random_traffic(5'd7, 8'd33, 350);
    idle_in_pct  = 0;
    idle_out_pct = 0;
    test_random_traffic(5'd16, 8'd16, 350);
    test_backpressure();
    test_random_traffic(5'd3, 8'd170, 300);

    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* eeprom_wear_level_ring.f */
design/ewl_pkg.sv
design/ewl_cfg.sv
design/ewl_ctrl.sv
design/ewl_dp.sv
design/eeprom_wear_level_ring.sv
tb/tb_eeprom_wear_level_ring.sv
